### rtl/assert_macros.svh
// Assertion helpers for the checker in clce_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define CLCE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent in the cycle after the antecedent.
`define CLCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/clce_pkg.sv
package clce_pkg;

	// command codes carried on s_tuser
	typedef enum logic [2:0] {
		MODE_BEGIN   = 3'd0,
		MODE_WRITE   = 3'd1,
		MODE_CURSOR  = 3'd2,
		MODE_SCR_L   = 3'd3,
		MODE_SCR_R   = 3'd4,
		MODE_CLEAR   = 3'd5,
		MODE_HOME    = 3'd6,
		MODE_FLAG    = 3'd7
	} mode_t;

	// flag selectors for MODE_FLAG
	localparam logic [2:0] FLAG_DISPLAY = 3'd0;
	localparam logic [2:0] FLAG_CURSOR  = 3'd1;
	localparam logic [2:0] FLAG_BLINK   = 3'd2;
	localparam logic [2:0] FLAG_LTR     = 3'd3;
	localparam logic [2:0] FLAG_ASCROLL = 3'd4;

	// configuration register indexes
	localparam logic CFG_NUM_COLS  = 1'b0;
	localparam logic CFG_NUM_LINES = 1'b1;

	// display command bytes
	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] CMD_HOME    = 8'h02;
	localparam logic [7:0] CMD_ENTRY   = 8'h04;
	localparam logic [7:0] CMD_DISPCTL = 8'h08;
	localparam logic [7:0] CMD_SCR_L   = 8'h18;
	localparam logic [7:0] CMD_SCR_R   = 8'h1C;
	localparam logic [7:0] CMD_FUNCSET = 8'h38;
	localparam logic [7:0] CMD_DDRAM   = 8'h80;

	localparam logic [2:0] DISP_ON     = 3'b100;
	localparam logic [1:0] ENTRY_LEFT  = 2'b10;
	localparam logic [1:0] ENTRY_SHIFT = 2'b01;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic signed [6:0] SCROLL_MAX = 7'sd39;
	localparam logic signed [6:0] SCROLL_MIN = -7'sd39;
	localparam logic signed [8:0] ADDR_MAX   = 9'sd39;
	localparam logic signed [8:0] WRAP_SPAN  = 9'sd40;

	localparam int unsigned MAX_WR = 4;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] char_code;
		logic [5:0] column;
		logic [1:0] row;
		logic [2:0] flag_index;
		logic       flag_value;
	} item_t;

	// one display bus write
	typedef struct packed {
		logic       rs;
		logic [7:0] data;
	} bus_wr_t;

	// all writes caused by one command, entry 0 first
	typedef struct packed {
		logic [2:0]              cnt;
		bus_wr_t [MAX_WR-1:0]    wr;
	} burst_t;

endpackage

### rtl/char_lcd_cursor_command_engine_core.sv
// Character LCD command front end. Each s_ transaction is one high-level
// command (begin, write char, set cursor, scroll left/right, clear, home, set
// flag); the block turns it into zero to four register-select/byte writes on
// the m_ side, the final one of each command marked with m_tlast. A command
// is held in one input register and decoded there against the tracked cursor,
// scroll and flag state; its writes are loaded as a group into a four-entry
// output buffer that drains one write per cycle while m_tready is high. A
// new command is taken in the same cycle the buffer hands out its last
// write, so commands' writes run back to back (one to four, begin is four);
// a command with no writes (CR/LF with nothing to reposition, unused flag
// index) leaves the buffer free. Stalls on m_tready hold everything upstream.
// cfg_ready is always high; write registers only while the block is idle.
module char_lcd_cursor_command_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	// command input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] char_code, [13:8] column, [15:14] row,
	                               // [18:16] flag_index, [19] flag_value, [23:20] zero
	input  logic [2:0]  s_tuser,   // [2:0] mode
	// display bus writes
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] bus_byte
	output logic        m_tuser,   // [0] register_select
	output logic        m_tlast,   // last write of the command
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index, // 0 num_cols, 1 num_lines
	input  logic [5:0]  cfg_data
);
	import clce_pkg::*;

	logic   valid_s1;
	item_t  item_s1;
	burst_t burst;
	logic   free;
	logic   step;

	// a command leaves the input register when the output buffer takes it
	assign step     = valid_s1 && free;
	assign s_tready = !valid_s1 || free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode       <= mode_t'(s_tuser);
			item_s1.char_code  <= s_tdata[7:0];
			item_s1.column     <= s_tdata[13:8];
			item_s1.row        <= s_tdata[15:14];
			item_s1.flag_index <= s_tdata[18:16];
			item_s1.flag_value <= s_tdata[19];
		end
	end

	// decode plus cursor/scroll/flag state
	clce_cmd u_cmd (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_idx (cfg_index),
		.cfg_val (cfg_data),
		.step    (step),
		.item    (item_s1),
		.burst   (burst)
	);

	// write buffer toward the display bus
	clce_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.burst    (burst),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### rtl/clce_cmd.sv
module clce_cmd (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_idx,
	input  logic [5:0]       cfg_val,
	input  logic             step,
	input  clce_pkg::item_t  item,
	output clce_pkg::burst_t burst
);
	import clce_pkg::*;

	logic [5:0]        num_cols_q;
	logic [2:0]        num_lines_q;
	logic [6:0]        col_q, col_n;
	logic [1:0]        row_q, row_n;
	logic              pend_q, pend_n;
	logic signed [6:0] scroll_q, scroll_n;
	logic [2:0]        disp_q, disp_n;
	logic [1:0]        entry_q, entry_n;
	logic              right_q, right_n;

	logic              is_cr, is_lf, row_inc;
	logic [7:0]        col_inc;
	logic [2:0]        row_nx;
	logic [2:0]        flag_bit;

	function automatic logic [7:0] cur_addr(input logic [6:0] col, input logic [1:0] row,
		input logic [5:0] ncols, input logic signed [6:0] scr);
		logic [6:0]        base;
		logic signed [8:0] a, b, c, sum;
		case (row)
			2'd0:    base = 7'h00;
			2'd1:    base = 7'h40;
			2'd2:    base = {1'b0, ncols};
			default: base = 7'h40 + {1'b0, ncols};
		endcase
		a   = {2'b00, col};
		b   = {3'b000, base[5:0]};
		c   = {{2{scr[6]}}, scr};
		sum = a + b + c;
		// one wrap at 40 either way
		if (sum > ADDR_MAX) sum = sum - WRAP_SPAN;
		if (sum < 0)        sum = sum + WRAP_SPAN;
		return CMD_DDRAM | {1'b0, sum[6:0]} | {1'b0, base[6], 6'b0};
	endfunction

	assign is_cr    = (item.char_code == CH_CR);
	assign is_lf    = (item.char_code == CH_LF);
	assign col_inc  = {1'b0, col_q} + 8'd1;
	assign flag_bit = DISP_ON >> item.flag_index;

	always_comb begin
		col_n    = col_q;
		row_n    = row_q;
		pend_n   = pend_q;
		scroll_n = scroll_q;
		disp_n   = disp_q;
		entry_n  = entry_q;
		right_n  = right_q;
		row_inc  = 1'b0;
		row_nx   = {1'b0, row_q};
		burst    = '0;
		unique case (item.mode)
			MODE_BEGIN: begin
				disp_n   = DISP_ON;
				scroll_n = '0;
				entry_n  = ENTRY_LEFT;
				burst.cnt   = 3'd4;
				burst.wr[0] = '{rs: 1'b0, data: CMD_FUNCSET};
				burst.wr[1] = '{rs: 1'b0, data: CMD_DISPCTL | {5'b0, DISP_ON}};
				burst.wr[2] = '{rs: 1'b0, data: CMD_CLEAR};
				burst.wr[3] = '{rs: 1'b0, data: CMD_ENTRY | {6'b0, ENTRY_LEFT}};
			end
			MODE_WRITE: begin
				if (scroll_q != 0 || pend_q) begin
					burst.wr[0] = '{rs: 1'b0,
						data: cur_addr(col_q, row_q, num_cols_q, scroll_q)};
					burst.wr[1] = '{rs: 1'b1, data: item.char_code};
					burst.cnt   = (is_cr || is_lf) ? 3'd1 : 3'd2;
				end else begin
					burst.wr[0] = '{rs: 1'b1, data: item.char_code};
					burst.cnt   = (is_cr || is_lf) ? 3'd0 : 3'd1;
				end
				if (right_q) begin
					if (is_cr || col_inc >= {2'b00, num_cols_q}) begin
						col_n   = '0;
						row_inc = 1'b1;
					end else begin
						col_n   = col_inc[6:0];
					end
				end else begin
					if (is_lf || col_q == '0) begin
						col_n   = {1'b0, num_cols_q} - 7'd1;
						row_inc = 1'b1;
					end else begin
						col_n   = col_q - 7'd1;
					end
				end
				pend_n = row_inc;
				row_nx = {1'b0, row_q} + {2'b00, row_inc};
				row_n  = (row_nx >= num_lines_q) ? 2'd0 : row_nx[1:0];
			end
			MODE_CURSOR: begin
				col_n  = {1'b0, item.column};
				row_n  = item.row;
				pend_n = 1'b0;
				burst.cnt   = 3'd1;
				burst.wr[0] = '{rs: 1'b0,
					data: cur_addr({1'b0, item.column}, item.row, num_cols_q, scroll_q)};
			end
			MODE_SCR_L: begin
				scroll_n    = (scroll_q == SCROLL_MAX) ? 7'sd0 : scroll_q + 7'sd1;
				burst.cnt   = 3'd1;
				burst.wr[0] = '{rs: 1'b0, data: CMD_SCR_L};
			end
			MODE_SCR_R: begin
				scroll_n    = (scroll_q == SCROLL_MIN) ? 7'sd0 : scroll_q - 7'sd1;
				burst.cnt   = 3'd1;
				burst.wr[0] = '{rs: 1'b0, data: CMD_SCR_R};
			end
			MODE_CLEAR: begin
				scroll_n    = '0;
				burst.cnt   = 3'd1;
				burst.wr[0] = '{rs: 1'b0, data: CMD_CLEAR};
			end
			MODE_HOME: begin
				scroll_n    = '0;
				burst.cnt   = 3'd1;
				burst.wr[0] = '{rs: 1'b0, data: CMD_HOME};
			end
			MODE_FLAG: begin
				case (item.flag_index) inside
					FLAG_DISPLAY, FLAG_CURSOR, FLAG_BLINK: begin
						disp_n      = item.flag_value ? (disp_q | flag_bit)
							: (disp_q & ~flag_bit);
						burst.cnt   = 3'd1;
						burst.wr[0] = '{rs: 1'b0, data: CMD_DISPCTL | {5'b0, disp_n}};
					end
					FLAG_LTR: begin
						entry_n     = item.flag_value ? (entry_q | ENTRY_LEFT)
							: (entry_q & ~ENTRY_LEFT);
						right_n     = item.flag_value;
						burst.cnt   = 3'd1;
						burst.wr[0] = '{rs: 1'b0, data: CMD_ENTRY | {6'b0, entry_n}};
					end
					FLAG_ASCROLL: begin
						entry_n     = item.flag_value ? (entry_q | ENTRY_SHIFT)
							: (entry_q & ~ENTRY_SHIFT);
						burst.cnt   = 3'd1;
						burst.wr[0] = '{rs: 1'b0, data: CMD_ENTRY | {6'b0, entry_n}};
					end
					default: ;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q  <= 6'd16;
			num_lines_q <= 3'd2;
			col_q       <= '0;
			row_q       <= '0;
			pend_q      <= 1'b0;
			scroll_q    <= '0;
			disp_q      <= '0;
			entry_q     <= '0;
			right_q     <= 1'b1;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_NUM_COLS:  num_cols_q  <= cfg_val;
					CFG_NUM_LINES: num_lines_q <= cfg_val[2:0];
				endcase
			end
			if (step) begin
				col_q    <= col_n;
				row_q    <= row_n;
				pend_q   <= pend_n;
				scroll_q <= scroll_n;
				disp_q   <= disp_n;
				entry_q  <= entry_n;
				right_q  <= right_n;
			end
		end
	end

endmodule

### rtl/clce_out.sv
module clce_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  clce_pkg::burst_t burst,
	output logic             free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);
	import clce_pkg::*;

	logic [2:0]           rem_q;
	bus_wr_t [MAX_WR-1:0] wr_q;
	logic                 busy, pop, take;

	assign busy = (rem_q != '0);
	assign pop  = busy && m_tready;
	// free when empty or the final write of the burst leaves now
	assign free = !busy || (pop && rem_q == 3'd1);
	assign take = in_valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (take) begin
			rem_q <= burst.cnt;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			wr_q <= burst.wr;
		end else if (pop) begin
			wr_q <= {bus_wr_t'('0), wr_q[MAX_WR-1:1]};
		end
	end

	assign m_tvalid = busy;
	assign m_tdata  = wr_q[0].data;
	assign m_tuser  = wr_q[0].rs;
	assign m_tlast  = (rem_q == 3'd1);

endmodule

### rtl/clce_chk.sv
`include "assert_macros.svh"

module clce_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);
	import clce_pkg::*;

	localparam logic [7:0] BYTE_DISP_ON = CMD_DISPCTL | {5'b0, DISP_ON};

	// stalled write holds
	`CLCE_ASSERT_NEXT(a_m_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "m_ write changed while stalled")

	// a data byte is always the final write of its command
	`CLCE_ASSERT_SAME(a_data_last, clk, arst_n, m_tvalid && m_tuser, m_tlast, "data write not marked last")

	// function set from begin is followed directly by display on
	`CLCE_ASSERT_NEXT(a_begin_seq, clk, arst_n, m_tvalid && m_tready && !m_tuser && m_tdata == CMD_FUNCSET, m_tvalid && !m_tuser && m_tdata == BYTE_DISP_ON, "begin sequence broken")

	// input only backs up behind a pending output write
	`CLCE_ASSERT_SAME(a_bp_src, clk, arst_n, !s_tready, m_tvalid, "input stalled with output idle")

endmodule

bind char_lcd_cursor_command_engine_core clce_chk u_chk (.*);

### bench/tb_char_lcd_cursor_command_engine_core.sv
module tb_char_lcd_cursor_command_engine_core;
	timeunit 1ns;
	timeprecision 1ps;

	import clce_pkg::*;

	// cycles with no transaction on any channel before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	// cycles allowed for a command with no bus writes to pass through
	localparam int SETTLE_CYCLES = 8;

	// one expected display bus write
	typedef struct {
		logic       rs;
		logic [7:0] bus_byte;
		logic       last;
	} lcd_write_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [7:0] char_code, [13:8] column, [15:14] row,
	                        // [18:16] flag_index, [19] flag_value, [23:20] zero
	logic [2:0]  s_tuser;   // [2:0] mode
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] bus_byte
	logic        m_tuser;   // [0] register_select
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [5:0]  cfg_data;

	char_lcd_cursor_command_engine_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// bus writes predicted but not yet seen, oldest first
	lcd_write_t expected_writes[$];
	int         error_count = 0;
	int         quiet_cycles = 0;

	// idling switches and the long receiver hold-off request
	bit sender_idle   = 1'b1;
	bit receiver_idle = 1'b1;
	int hold_cycles   = 0;

	// shadow of the display geometry registers
	logic [5:0] lcd_cols;
	logic [2:0] lcd_lines;

	// shadow of the tracked display state
	logic [6:0] cur_col;
	logic [1:0] cur_row;
	logic       reposition_due;
	int         pan_offset;
	logic [2:0] disp_bits;
	logic [1:0] entry_bits;
	logic       rightward;

	task automatic reset_display_shadow();
		lcd_cols       = 6'd16;
		lcd_lines      = 3'd2;
		cur_col        = '0;
		cur_row        = '0;
		reposition_due = 1'b0;
		pan_offset     = 0;
		disp_bits      = '0;
		entry_bits     = '0;
		rightward      = 1'b1;
	endtask

	// DDRAM set-address byte for a cursor position, scroll corrected
	function automatic logic [7:0] ddram_address(logic [6:0] col, logic [1:0] row);
		logic [6:0] base;
		int         sum;
		case (row)
			2'd0: begin
				base = 7'h00;
			end
			2'd1: begin
				base = 7'h40;
			end
			2'd2: begin
				base = {1'b0, lcd_cols};
			end
			default: begin
				base = 7'h40 + {1'b0, lcd_cols};
			end
		endcase
		sum = int'(col) + int'(base[5:0]) + pan_offset;
		// one wrap only, in either direction
		if (sum > 39)
			sum -= 40;
		if (sum < 0)
			sum += 40;
		return CMD_DDRAM | {1'b0, sum[6:0]} | {1'b0, base[6], 6'd0};
	endfunction

	// update the shadow state for one command and queue the writes it causes
	task automatic predict_bus_writes(item_t cmd);
		lcd_write_t burst[$];
		int         next_row;
		int         next_col;
		logic [2:0] bit_sel;
		case (cmd.mode)
			MODE_BEGIN: begin
				burst.push_back('{1'b0, CMD_FUNCSET, 1'b0});
				disp_bits = DISP_ON;
				burst.push_back('{1'b0, CMD_DISPCTL | {5'd0, disp_bits}, 1'b0});
				burst.push_back('{1'b0, CMD_CLEAR, 1'b0});
				pan_offset = 0;
				entry_bits = ENTRY_LEFT;
				burst.push_back('{1'b0, CMD_ENTRY | {6'd0, entry_bits}, 1'b0});
			end
			MODE_WRITE: begin
				// reposition first if the display moved or a line wrapped
				if (pan_offset != 0 || reposition_due)
					burst.push_back('{1'b0, ddram_address(cur_col, cur_row), 1'b0});
				// CR and LF only move the cursor
				if (cmd.char_code != CH_CR && cmd.char_code != CH_LF)
					burst.push_back('{1'b1, cmd.char_code, 1'b0});
				reposition_due = 1'b0;
				next_row = int'(cur_row);
				if (rightward) begin
					next_col = int'(cur_col) + 1;
					if (cmd.char_code == CH_CR || next_col >= int'(lcd_cols)) begin
						next_col = 0;
						next_row++;
						reposition_due = 1'b1;
					end
					cur_col = next_col[6:0];
				end else begin
					if (cmd.char_code == CH_LF || cur_col == 7'd0) begin
						// zero columns wraps to 127
						cur_col = {1'b0, lcd_cols} - 7'd1;
						next_row++;
						reposition_due = 1'b1;
					end else begin
						cur_col = cur_col - 7'd1;
					end
				end
				if (next_row >= int'(lcd_lines))
					next_row = 0;
				cur_row = next_row[1:0];
			end
			MODE_CURSOR: begin
				cur_col = {1'b0, cmd.column};
				cur_row = cmd.row;
				reposition_due = 1'b0;
				burst.push_back('{1'b0, ddram_address(cur_col, cur_row), 1'b0});
			end
			MODE_SCR_L: begin
				burst.push_back('{1'b0, CMD_SCR_L, 1'b0});
				pan_offset++;
				if (pan_offset >= 40)
					pan_offset -= 40;
			end
			MODE_SCR_R: begin
				burst.push_back('{1'b0, CMD_SCR_R, 1'b0});
				pan_offset--;
				if (pan_offset <= -40)
					pan_offset += 40;
			end
			MODE_CLEAR: begin
				burst.push_back('{1'b0, CMD_CLEAR, 1'b0});
				pan_offset = 0;
			end
			MODE_HOME: begin
				burst.push_back('{1'b0, CMD_HOME, 1'b0});
				pan_offset = 0;
			end
			default: begin
				case (cmd.flag_index) inside
					FLAG_DISPLAY, FLAG_CURSOR, FLAG_BLINK: begin
						bit_sel = 3'b100 >> cmd.flag_index;
						if (cmd.flag_value)
							disp_bits = disp_bits | bit_sel;
						else
							disp_bits = disp_bits & ~bit_sel;
						burst.push_back('{1'b0, CMD_DISPCTL | {5'd0, disp_bits}, 1'b0});
					end
					FLAG_LTR: begin
						if (cmd.flag_value)
							entry_bits = entry_bits | ENTRY_LEFT;
						else
							entry_bits = entry_bits & ~ENTRY_LEFT;
						rightward = cmd.flag_value;
						burst.push_back('{1'b0, CMD_ENTRY | {6'd0, entry_bits}, 1'b0});
					end
					FLAG_ASCROLL: begin
						if (cmd.flag_value)
							entry_bits = entry_bits | ENTRY_SHIFT;
						else
							entry_bits = entry_bits & ~ENTRY_SHIFT;
						burst.push_back('{1'b0, CMD_ENTRY | {6'd0, entry_bits}, 1'b0});
					end
					default: begin
						// unused selector: no state change, no write
					end
				endcase
			end
		endcase
		if (burst.size() > 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			expected_writes.push_back(burst[i]);
	endtask

	function automatic item_t make_command(mode_t mode, logic [7:0] char_code,
			logic [5:0] column, logic [1:0] row, logic [2:0] flag_index,
			logic flag_value);
		item_t cmd;
		cmd.mode       = mode;
		cmd.char_code  = char_code;
		cmd.column     = column;
		cmd.row        = row;
		cmd.flag_index = flag_index;
		cmd.flag_value = flag_value;
		return cmd;
	endfunction

	// mostly text runs and cursor moves, with scrolls, flags and resets mixed in
	function automatic item_t random_command();
		item_t cmd;
		int    pick;
		cmd = make_command(MODE_WRITE, 8'($urandom_range(0, 255)),
			6'($urandom_range(0, 39)), 2'($urandom_range(0, 3)),
			3'($urandom_range(0, 4)), 1'($urandom_range(0, 1)));
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			if ($urandom_range(0, 9) == 0)
				cmd.char_code = $urandom_range(0, 1) ? CH_CR : CH_LF;
		end else if (pick < 62) begin
			cmd.mode = MODE_CURSOR;
		end else if (pick < 69) begin
			cmd.mode = MODE_SCR_L;
		end else if (pick < 76) begin
			cmd.mode = MODE_SCR_R;
		end else if (pick < 88) begin
			cmd.mode = MODE_FLAG;
			if ($urandom_range(0, 9) == 0)
				cmd.flag_index = 3'($urandom_range(5, 7));
		end else if (pick < 93) begin
			cmd.mode = MODE_CLEAR;
		end else if (pick < 97) begin
			cmd.mode = MODE_HOME;
		end else begin
			cmd.mode = MODE_BEGIN;
		end
		return cmd;
	endfunction

	// offer one command and wait for its transaction; s_tvalid stays high
	// afterwards so back-to-back commands need no extra edge
	task automatic send_command(item_t cmd);
		int gap;
		bit taken;
		gap = sender_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd.mode;
		s_tdata  <= {4'd0, cmd.flag_value, cmd.flag_index, cmd.row, cmd.column,
			cmd.char_code};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		predict_bus_writes(cmd);
	endtask

	// idle the input and let every outstanding write drain
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (expected_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both geometry registers back to back while the block is idle
	task automatic configure(logic [5:0] cols, logic [2:0] lines);
		bit taken;
		wait_for_drain();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_NUM_COLS;
		cfg_data  <= cols;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		lcd_cols = cols;
		cfg_index <= CFG_NUM_LINES;
		cfg_data  <= {3'd0, lines};
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		lcd_lines = lines;
		cfg_valid <= 1'b0;
	endtask

	// data byte extremes, CR/LF with and without a pending reposition,
	// every flag selector, scrolls, clear, home, cursor corners, leftward wrap
	task automatic test_directed_commands();
		send_command(make_command(MODE_WRITE, 8'h41, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_WRITE, CH_CR, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_WRITE, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_WRITE, CH_LF, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_WRITE, 8'hFF, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_BEGIN, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0));
		for (int i = 0; i < 8; i++)
			send_command(make_command(MODE_FLAG, 8'h00, 6'd0, 2'd0, 3'(i), 1'b1));
		send_command(make_command(MODE_FLAG, 8'h00, 6'd0, 2'd0, FLAG_DISPLAY, 1'b0));
		send_command(make_command(MODE_FLAG, 8'h00, 6'd0, 2'd0, FLAG_ASCROLL, 1'b0));
		send_command(make_command(MODE_FLAG, 8'h00, 6'd0, 2'd0, FLAG_LTR, 1'b0));
		send_command(make_command(MODE_SCR_L, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_SCR_R, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_SCR_R, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0));
		// scrolled display: address then data, cursor moving left
		send_command(make_command(MODE_WRITE, 8'h7E, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_CLEAR, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_CURSOR, 8'h00, 6'd39, 2'd3, 3'd0, 1'b0));
		send_command(make_command(MODE_CURSOR, 8'h00, 6'd0, 2'd0, 3'd7, 1'b1));
		// column 0 leftward: wraps to the line end of the next row
		send_command(make_command(MODE_WRITE, CH_LF, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_WRITE, 8'h80, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_HOME, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0));
	endtask

	// geometry outside the usual range: zero columns/lines, oversized values,
	// and a row stepping past 3
	task automatic test_odd_settings();
		configure(6'd0, 3'd0);
		send_command(make_command(MODE_CURSOR, 8'h00, 6'd39, 2'd3, 3'd0, 1'b0));
		send_command(make_command(MODE_WRITE, 8'h31, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_WRITE, 8'h32, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_FLAG, 8'h00, 6'd0, 2'd0, FLAG_LTR, 1'b1));
		send_command(make_command(MODE_WRITE, 8'h33, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_WRITE, 8'h34, 6'd0, 2'd0, 3'd0, 1'b0));
		configure(6'd63, 3'd7);
		send_command(make_command(MODE_CURSOR, 8'h00, 6'd39, 2'd3, 3'd0, 1'b0));
		send_command(make_command(MODE_CURSOR, 8'h00, 6'd39, 2'd2, 3'd0, 1'b0));
		send_command(make_command(MODE_SCR_R, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_WRITE, 8'h35, 6'd0, 2'd0, 3'd0, 1'b0));
		configure(6'd40, 3'd7);
		send_command(make_command(MODE_CURSOR, 8'h00, 6'd39, 2'd3, 3'd0, 1'b0));
		send_command(make_command(MODE_WRITE, 8'h36, 6'd0, 2'd0, 3'd0, 1'b0));
		send_command(make_command(MODE_WRITE, 8'h37, 6'd0, 2'd0, 3'd0, 1'b0));
	endtask

	// walk the scroll count through both wrap points with writes in between
	task automatic test_scroll_wrap();
		configure(6'd40, 3'd4);
		send_command(make_command(MODE_CURSOR, 8'h00, 6'd5, 2'd1, 3'd0, 1'b0));
		for (int i = 0; i < 41; i++) begin
			send_command(make_command(MODE_SCR_L, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0));
			if (i % 8 == 7)
				send_command(make_command(MODE_WRITE, 8'($urandom_range(32, 126)),
					6'd0, 2'd0, 3'd0, 1'b0));
		end
		for (int i = 0; i < 41; i++) begin
			send_command(make_command(MODE_SCR_R, 8'h00, 6'd0, 2'd0, 3'd0, 1'b0));
			if (i % 8 == 7)
				send_command(make_command(MODE_CURSOR, 8'h00, 6'($urandom_range(0, 39)),
					2'($urandom_range(0, 3)), 3'd0, 1'b0));
		end
	endtask

	// random traffic over several geometries, idling varied per phase
	task automatic test_random_phases();
		logic [5:0] cols;
		logic [2:0] lines;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					cols = 6'd1;
					lines = 3'd1;
				end
				1: begin
					cols = 6'd40;
					lines = 3'd4;
				end
				2: begin
					cols = 6'd16;
					lines = 3'd2;
				end
				default: begin
					cols = 6'($urandom_range(1, 40));
					lines = 3'($urandom_range(1, 4));
				end
			endcase
			configure(cols, lines);
			sender_idle   = (phase % 3 != 2);
			receiver_idle = (phase % 3 != 1);
			if (phase == 5) begin
				sender_idle   = 1'b0;
				receiver_idle = 1'b0;
			end
			for (int i = 0; i < 55; i++)
				send_command(random_command());
		end
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
	endtask

	// receiver holds off for a long stretch while commands keep coming
	task automatic test_backpressure();
		configure(6'd20, 3'd4);
		sender_idle = 1'b0;
		hold_cycles = 300;
		for (int i = 0; i < 40; i++)
			send_command(random_command());
		sender_idle = 1'b1;
	endtask

	// receiver: a random stall before each write, or the long hold when asked
	initial begin
		int stall;
		bit taken;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = receiver_idle ? $urandom_range(0, 10) : 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				taken = m_tvalid;
				@(posedge clk);
			end while (!taken);
		end
	end

	// checker and watchdog; signals are stable at the falling edge, and a
	// transaction seen here completes at the next rising edge
	always @(negedge clk) begin
		lcd_write_t want;
		if (arst_n === 1'b1) begin
			if (m_tvalid && m_tready) begin
				if (expected_writes.size() == 0) begin
					$display("%0t: unexpected bus write rs=%b byte=%h last=%b",
						$realtime, m_tuser, m_tdata, m_tlast);
					error_count++;
				end else begin
					want = expected_writes.pop_front();
					if (m_tuser !== want.rs) begin
						$display("%0t: register_select expected %b actual %b",
							$realtime, want.rs, m_tuser);
						error_count++;
					end
					if (m_tdata !== want.bus_byte) begin
						$display("%0t: bus_byte expected %h actual %h",
							$realtime, want.bus_byte, m_tdata);
						error_count++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last expected %b actual %b",
							$realtime, want.last, m_tlast);
						error_count++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= MODE_BEGIN;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_NUM_COLS;
		cfg_data  <= '0;
		reset_display_shadow();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_commands();
		test_odd_settings();
		test_scroll_wrap();
		test_random_phases();
		test_backpressure();

		wait_for_drain();
		if (error_count == 0 && expected_writes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/clce_pkg.sv
rtl/clce_cmd.sv
rtl/clce_out.sv
rtl/char_lcd_cursor_command_engine_core.sv
rtl/clce_chk.sv
bench/tb_char_lcd_cursor_command_engine_core.sv
